// File: rtl/core/tmt_pkg.sv
// Package for the TinyMT32 generator: constants, datapath functions and the microcode table.
`timescale 1ns / 1ps
package tmt_pkg;

  localparam int WordW  = 32;
  localparam int PcW    = 5;
  localparam int ImmW   = 3;
  localparam int CntW   = 3;
  localparam int CfgIdxW = 2;

  typedef logic [WordW-1:0] word_t;
  typedef word_t [3:0] state_t;

  // Mixing multiplier and tempering/advance shift amounts.
  localparam word_t MixMul  = 32'd1812433253;
  localparam int    Sh0     = 1;
  localparam int    Sh1     = 10;
  localparam int    Sh8     = 8;
  localparam word_t MaskW0  = 32'h7fff_ffff;

  // Reset values of the parameter registers.
  localparam word_t Mat1Reset   = 32'h8f70_11ee;
  localparam word_t Mat2Reset   = 32'hfc78_ff1f;
  localparam word_t TemperReset = 32'h3793_fdff;

  // Replacement state for a degenerate seed ("HACK").
  localparam word_t FixW0 = 32'h0000_0048;
  localparam word_t FixW1 = 32'h0000_0041;
  localparam word_t FixW2 = 32'h0000_0043;
  localparam word_t FixW3 = 32'h0000_004b;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgMat1   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMat2   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTemper = 2'd2;

  // Datapath operations selected by the control word.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_MUL,
    OP_MIX,
    OP_ROT,
    OP_CHECK,
    OP_ADV,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [ImmW-1:0] imm;
    logic            repeat8;
    logic            last;
  } ctrl_t;

  // Program entry points and the length of the program.
  localparam logic [PcW-1:0] SeedEntry = 5'd0;
  localparam logic [PcW-1:0] NextEntry = 5'd17;
  localparam logic [PcW-1:0] ProgLen   = 5'd19;

  // Microcode table. Seeding: seven multiply/xor rounds with word rotation,
  // a final rotation back into place, the period check, then eight advances.
  // Next: one advance, then temper and emit.
  function automatic ctrl_t rom(input logic [PcW-1:0] addr);
    ctrl_t c;
    c = '{op: OP_NOP, imm: '0, repeat8: 1'b0, last: 1'b1};
    unique case (addr)
      5'd0:  c = '{op: OP_MUL,   imm: 3'd0, repeat8: 1'b0, last: 1'b0};
      5'd1:  c = '{op: OP_MIX,   imm: 3'd1, repeat8: 1'b0, last: 1'b0};
      5'd2:  c = '{op: OP_MUL,   imm: 3'd0, repeat8: 1'b0, last: 1'b0};
      5'd3:  c = '{op: OP_MIX,   imm: 3'd2, repeat8: 1'b0, last: 1'b0};
      5'd4:  c = '{op: OP_MUL,   imm: 3'd0, repeat8: 1'b0, last: 1'b0};
      5'd5:  c = '{op: OP_MIX,   imm: 3'd3, repeat8: 1'b0, last: 1'b0};
      5'd6:  c = '{op: OP_MUL,   imm: 3'd0, repeat8: 1'b0, last: 1'b0};
      5'd7:  c = '{op: OP_MIX,   imm: 3'd4, repeat8: 1'b0, last: 1'b0};
      5'd8:  c = '{op: OP_MUL,   imm: 3'd0, repeat8: 1'b0, last: 1'b0};
      5'd9:  c = '{op: OP_MIX,   imm: 3'd5, repeat8: 1'b0, last: 1'b0};
      5'd10: c = '{op: OP_MUL,   imm: 3'd0, repeat8: 1'b0, last: 1'b0};
      5'd11: c = '{op: OP_MIX,   imm: 3'd6, repeat8: 1'b0, last: 1'b0};
      5'd12: c = '{op: OP_MUL,   imm: 3'd0, repeat8: 1'b0, last: 1'b0};
      5'd13: c = '{op: OP_MIX,   imm: 3'd7, repeat8: 1'b0, last: 1'b0};
      5'd14: c = '{op: OP_ROT,   imm: 3'd0, repeat8: 1'b0, last: 1'b0};
      5'd15: c = '{op: OP_CHECK, imm: 3'd0, repeat8: 1'b0, last: 1'b0};
      5'd16: c = '{op: OP_ADV,   imm: 3'd0, repeat8: 1'b1, last: 1'b1};
      5'd17: c = '{op: OP_ADV,   imm: 3'd0, repeat8: 1'b0, last: 1'b0};
      5'd18: c = '{op: OP_EMIT,  imm: 3'd0, repeat8: 1'b0, last: 1'b1};
      default: c = '{op: OP_NOP, imm: 3'd0, repeat8: 1'b0, last: 1'b1};
    endcase
    return c;
  endfunction

  // One state transition of the generator.
  function automatic state_t advance(input state_t w, input word_t mat1, input word_t mat2);
    word_t  x;
    word_t  y;
    state_t n;
    y = w[3];
    x = (w[0] & MaskW0) ^ w[1] ^ w[2];
    x = x ^ (x << Sh0);
    y = y ^ (y >> Sh0) ^ x;
    n[0] = w[1];
    n[1] = w[2] ^ (y[0] ? mat1 : '0);
    n[2] = x ^ (y << Sh1) ^ (y[0] ? mat2 : '0);
    n[3] = y;
    return n;
  endfunction

  // Output tempering of the current state.
  function automatic word_t temper(input state_t w, input word_t tmat);
    word_t t1;
    t1 = w[0] + (w[2] >> Sh8);
    return w[3] ^ t1 ^ (t1[0] ? tmat : '0);
  endfunction

endpackage

// File: rtl/core/tinymt32_generator.sv
// Top level of the TinyMT32 generator: microcoded sequencer and datapath.
`timescale 1ns / 1ps
// Usage
// Input channel (in_valid/in_stall, kind, seed_value): a request with kind 0
// reseeds the generator from seed_value and produces no result; a request
// with kind 1 advances the state once and produces one random_value.
// Output channel (out_valid/out_stall, random_value): one registered result.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data): writes mat1,
// mat2 and the tempering word; indexes beyond two are ignored. Write only
// while the block is idle.
// Timing: a request is taken only while the sequencer is idle. A next
// request passes through accept, advance and temper steps, and its result
// is registered in the temper step. A seed request passes through accept,
// seven rounds of two steps each through the single 32x32 multiplier, a
// rotation, the period check and eight advances.
// Reset clears the state words to zero and loads the default parameters.
// If the receiver stalls, the result stays in the output register and the
// temper step waits, so the next request is held off until it is taken.
module tinymt32_generator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            kind,
  input  logic [tmt_pkg::WordW-1:0]       seed_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tmt_pkg::WordW-1:0]       random_value,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tmt_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [tmt_pkg::WordW-1:0]       cfg_data
);
  import tmt_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } seq_state_t;

  seq_state_t      state;
  logic [PcW-1:0]  pc;
  logic [CntW-1:0] cnt;
  state_t          tw;
  word_t           prod;
  word_t           mat1;
  word_t           mat2;
  word_t           tmat;

  ctrl_t           ctrl;
  logic            step_go;
  logic            stay;
  logic            in_take;
  state_t          tw_adv;
  word_t           mix_word;
  logic            degenerate;

  // Current control word and step enable; the emit step waits for room.
  always_comb begin
    ctrl    = rom(pc);
    step_go = (state == S_RUN) &&
              !((ctrl.op == OP_EMIT) && out_valid && out_stall) &&
              (pc < ProgLen || ctrl.last);
    stay    = ctrl.repeat8 && (cnt != '1);
    in_take = in_valid && !in_stall;
  end

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Datapath helpers.
  always_comb begin
    tw_adv     = advance(tw, mat1, mat2);
    mix_word   = tw[1] ^ ({{(WordW-ImmW){1'b0}}, ctrl.imm} + prod);
    degenerate = ((tw[0] & MaskW0) == '0) && (tw[1] == '0) &&
                 (tw[2] == '0) && (tw[3] == '0);
  end

  // Sequencer, datapath registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= SeedEntry;
      cnt       <= '0;
      tw        <= '0;
      out_valid <= 1'b0;
      mat1      <= Mat1Reset;
      mat2      <= Mat2Reset;
      tmat      <= TemperReset;
    end else begin
      // Configuration writes.
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CfgMat1:   mat1 <= cfg_data;
          CfgMat2:   mat2 <= cfg_data;
          CfgTemper: tmat <= cfg_data;
          default: ;
        endcase
      end

      // The receiver takes the pending result, unless a new one lands now.
      if (out_valid && !out_stall && !(step_go && (ctrl.op == OP_EMIT))) begin
        out_valid <= 1'b0;
      end

      // Accept a request and pick its program.
      if (in_take) begin
        state <= S_RUN;
        cnt   <= '0;
        if (kind) begin
          pc <= NextEntry;
        end else begin
          pc <= SeedEntry;
          tw <= '{tmat, mat2, mat1, seed_value};
        end
      end

      // Execute one control word.
      if (step_go) begin
        unique case (ctrl.op)
          OP_NOP:   ;
          OP_MUL:   prod <= MixMul * (tw[0] ^ (tw[0] >> 30));
          OP_MIX:   tw <= '{tw[0], tw[3], tw[2], mix_word};
          OP_ROT:   tw <= '{tw[0], tw[3], tw[2], tw[1]};
          OP_CHECK: begin
            if (degenerate) begin
              tw <= '{FixW3, FixW2, FixW1, FixW0};
            end
          end
          OP_ADV:   tw <= tw_adv;
          OP_EMIT:  begin
            random_value <= temper(tw, tmat);
            out_valid    <= 1'b1;
          end
          default: ;
        endcase

        // Step counter with the repeat-eight loop.
        if (stay) begin
          cnt <= cnt + 1'b1;
        end else begin
          cnt <= '0;
          if (ctrl.last) begin
            state <= S_IDLE;
          end else begin
            pc <= pc + 1'b1;
          end
        end
      end
    end
  end

endmodule

// File: tb/sv/tinymt32_generator_checker.sv
// Checker for the TinyMT32 generator: watches all channels, predicts each random word and compares.
`timescale 1ns / 1ps
module tinymt32_generator_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        kind,
  input  logic [31:0] seed_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] random_value,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          failures,
  output int          outstanding,
  output int          checked,
  output int          seeds
);

  typedef logic [31:0] word32_t;
  typedef logic [3:0][31:0] twister_t;

  localparam bit      KindSeed   = 1'b0;
  localparam word32_t LowMask    = 32'h7fff_ffff;
  localparam word32_t MixFactor  = 32'd1812433253;
  localparam int      MixRounds  = 8;
  localparam int      WarmUp     = 8;
  // Letters H, A, C and K that replace a state with no usable bits.
  localparam word32_t RescueW0   = 32'h0000_0048;
  localparam word32_t RescueW1   = 32'h0000_0041;
  localparam word32_t RescueW2   = 32'h0000_0043;
  localparam word32_t RescueW3   = 32'h0000_004b;
  localparam word32_t Mat1Init   = 32'h8f70_11ee;
  localparam word32_t Mat2Init   = 32'hfc78_ff1f;
  localparam word32_t TemperInit = 32'h3793_fdff;

  twister_t twister_q;
  word32_t  mat1_q;
  word32_t  mat2_q;
  word32_t  temper_q;
  word32_t  expected_words[$];
  int       fail_count;
  int       check_count;
  int       seed_count;

  // One shift-xor transition of the four state words.
  function automatic twister_t advance_twister(twister_t w, word32_t m1, word32_t m2);
    word32_t  x;
    word32_t  y;
    twister_t n;
    y = w[3];
    x = (w[0] & LowMask) ^ w[1] ^ w[2];
    x = x ^ (x << 1);
    y = y ^ (y >> 1) ^ x;
    n[0] = w[1];
    n[1] = w[2];
    n[2] = x ^ (y << 10);
    n[3] = y;
    if (y[0]) begin
      n[1] = n[1] ^ m1;
      n[2] = n[2] ^ m2;
    end
    return n;
  endfunction

  // Tempered output word of the present state.
  function automatic word32_t temper_twister(twister_t w, word32_t tm);
    word32_t sum;
    word32_t r;
    sum = w[0] + (w[2] >> 8);
    r = w[3] ^ sum;
    if (sum[0]) begin
      r = r ^ tm;
    end
    return r;
  endfunction

  // Seeding: load, mix, rescue an empty state, then warm up.
  function automatic twister_t seed_twister(word32_t sv, word32_t m1, word32_t m2,
                                            word32_t tm);
    twister_t w;
    word32_t  prev;
    int       i;
    w[0] = sv;
    w[1] = m1;
    w[2] = m2;
    w[3] = tm;
    for (i = 1; i < MixRounds; i++) begin
      prev = w[(i - 1) % 4];
      w[i % 4] = w[i % 4] ^ (word32_t'(i) + MixFactor * (prev ^ (prev >> 30)));
    end
    if ((w[0] & LowMask) == '0 && w[1] == '0 && w[2] == '0 && w[3] == '0) begin
      w[0] = RescueW0;
      w[1] = RescueW1;
      w[2] = RescueW2;
      w[3] = RescueW3;
    end
    for (i = 0; i < WarmUp; i++) begin
      w = advance_twister(w, m1, m2);
    end
    return w;
  endfunction

  // Track register writes and requests, and compare each result taken.
  always @(posedge clk) begin : monitor
    word32_t want;
    if (rst) begin
      twister_q = '0;
      mat1_q = Mat1Init;
      mat2_q = Mat2Init;
      temper_q = TemperInit;
      expected_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tmt_pkg::CfgMat1:   mat1_q = cfg_data;
          tmt_pkg::CfgMat2:   mat2_q = cfg_data;
          tmt_pkg::CfgTemper: temper_q = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("random_value: expected none, actual %h", random_value);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          check_count++;
          if (random_value !== want) begin
            $error("random_value mismatch: expected %h, actual %h", want, random_value);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (kind == KindSeed) begin
          twister_q = seed_twister(seed_value, mat1_q, mat2_q, temper_q);
          seed_count++;
        end else begin
          twister_q = advance_twister(twister_q, mat1_q, mat2_q);
          expected_words.push_back(temper_twister(twister_q, temper_q));
        end
      end
    end
    failures <= fail_count;
    outstanding <= expected_words.size();
    checked <= check_count;
    seeds <= seed_count;
  end

endmodule

// File: tb/sv/tinymt32_generator_tb.sv
// Testbench top for the TinyMT32 generator: clock, reset, stimulus phases and the verdict.
`timescale 1ns / 1ps
module tinymt32_generator_tb;

  localparam bit         KindSeed      = 1'b0;
  localparam bit         KindNext      = 1'b1;
  localparam logic [1:0] CfgSpare      = 2'd3;
  localparam int         SettleCycles  = 40;
  localparam int         HoldCycles    = 300;
  localparam int         ItemsPerPhase = 385;
  localparam int         CycleLimit    = 600000;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        kind;
  logic [31:0] seed_value;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] random_value;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int cycle_count = 0;
  int requests_sent = 0;
  int failures;
  int outstanding;
  int checked;
  int seeds;

  always #2 clk = ~clk;

  tinymt32_generator DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .seed_value   (seed_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .random_value (random_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  tinymt32_generator_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .seed_value   (seed_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .random_value (random_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .failures     (failures),
    .outstanding  (outstanding),
    .checked      (checked),
    .seeds        (seeds)
  );

  // Give up once the run has gone far beyond its slowest correct length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tinymt32_generator test failed");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off whenever one is asked for.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offer one request, with random idle cycles ahead of it, and wait until it is taken.
  task automatic offer(input bit k, input logic [31:0] sv);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      kind <= 1'($urandom_range(1));
      seed_value <= $urandom;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    seed_value <= sv;
    do @(posedge clk); while (in_stall !== 1'b0);
    requests_sent++;
  endtask

  // Stop offering until every result is in and a seeding run has surely finished.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_words(input logic [31:0] m1, input logic [31:0] m2,
                            input logic [31:0] tm);
    drain();
    write_reg(tmt_pkg::CfgMat1, m1);
    write_reg(tmt_pkg::CfgMat2, m2);
    write_reg(tmt_pkg::CfgTemper, tm);
  endtask

  // Main stimulus: directed cases first, then four idling phases of random requests.
  initial begin : stimulus
    logic [31:0] mix_top;
    logic [31:0] dg_seed;
    logic [31:0] dg_w1;
    logic [31:0] dg_m1;
    logic [31:0] dg_m2;
    logic [31:0] dg_t;
    logic [31:0] sv;
    bit          k;
    int          v;
    int          p;
    int          i;

    rst <= 1'b1;
    in_valid <= 1'b0;
    kind <= 1'b0;
    seed_value <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Numbers asked for before any seed come from the all-zero state.
    offer(KindNext, 32'h0000_0000);
    offer(KindNext, 32'hffff_ffff);

    // Seed extremes with the reset parameters.
    offer(KindSeed, 32'h0000_0000);
    offer(KindNext, $urandom);
    offer(KindNext, $urandom);
    offer(KindSeed, 32'hffff_ffff);
    offer(KindNext, $urandom);
    offer(KindNext, $urandom);
    offer(KindSeed, 32'h8000_0000);
    offer(KindNext, $urandom);
    offer(KindSeed, 32'h0000_0001);
    offer(KindNext, $urandom);

    // A write to the unused index must change nothing.
    drain();
    write_reg(CfgSpare, $urandom);
    offer(KindNext, $urandom);

    // A tempering word changed after seeding applies to the next number.
    drain();
    write_reg(tmt_pkg::CfgTemper, $urandom);
    offer(KindNext, $urandom);

    // Parameters and seed chosen so that mixing leaves an empty state,
    // once with the top bit of word zero clear and once with it set.
    for (v = 0; v < 2; v++) begin
      mix_top = (v != 0) ? 32'h8000_0000 : 32'h0000_0000;
      dg_seed = mix_top ^ (32'd4 + tmt_pkg::MixMul * 32'd7);
      dg_w1 = 32'd5 + tmt_pkg::MixMul * (mix_top ^ (mix_top >> 30));
      dg_m1 = dg_w1 ^ (32'd1 + tmt_pkg::MixMul * (dg_seed ^ (dg_seed >> 30)));
      dg_m2 = 32'd6 ^ (32'd2 + tmt_pkg::MixMul * (dg_w1 ^ (dg_w1 >> 30)));
      dg_t = 32'd7 ^ (32'd3 + tmt_pkg::MixMul * 32'd6);
      load_words(dg_m1, dg_m2, dg_t);
      offer(KindSeed, dg_seed);
      offer(KindNext, $urandom);
      offer(KindNext, $urandom);
    end

    // Parameter extremes.
    load_words('0, '0, '0);
    offer(KindSeed, $urandom);
    offer(KindNext, $urandom);
    offer(KindNext, $urandom);
    load_words('1, '1, '1);
    offer(KindSeed, $urandom);
    offer(KindNext, $urandom);
    offer(KindNext, $urandom);

    // Random phases: no idling, idle sender, stalling receiver, both.
    for (p = 0; p < 4; p++) begin
      case (p)
        0: load_words(tmt_pkg::Mat1Reset, tmt_pkg::Mat2Reset, tmt_pkg::TemperReset);
        1: load_words($urandom, $urandom, $urandom);
        2: load_words('0, '0, '0);
        default: load_words('1, '1, '1);
      endcase
      idle_pct = (p == 1) ? 81 : (p == 3) ? 24 : 0;
      stall_pct = (p == 2) ? 81 : (p == 3) ? 24 : 0;
      for (i = 0; i < ItemsPerPhase; i++) begin
        // Long receiver hold-off while requests keep coming.
        if (p == 0 && i == 100) begin
          hold_requests <= hold_requests + 1;
        end
        // Let everything drain once in the middle of the last phase.
        if (p == 3 && i == ItemsPerPhase / 2) begin
          drain();
        end
        k = ($urandom_range(99) < 8) ? KindSeed : KindNext;
        case ($urandom_range(15))
          0: sv = 32'h0000_0000;
          1: sv = 32'hffff_ffff;
          default: sv = $urandom;
        endcase
        offer(k, sv);
      end
    end

    drain();
    $display("Run covered %0d requests, %0d of them reseeds, and checked %0d random words",
             requests_sent, seeds, checked);
    $display("across four idling phases, a long output hold-off and several parameter sets.");
    if (failures == 0) begin
      $display("tinymt32_generator test passed");
    end else begin
      $display("tinymt32_generator test failed");
    end
    $finish;
  end

endmodule
